FILE: src/qpld_pkg.sv
// ----------------------------------------------------------------------------
// qpld_pkg
// Shared types, constants and character helpers for the quoted-printable
// line decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package qpld_pkg;

   // Blank store: depth, count width and index width
   localparam int BLANK_DEPTH = 14;
   localparam int CNT_W       = $clog2(BLANK_DEPTH + 1);
   localparam int IDX_W       = (BLANK_DEPTH > 1) ? $clog2(BLANK_DEPTH) : 1;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Characters
   localparam logic [7:0] CH_EQ   = 8'h3D;
   localparam logic [7:0] CH_TAB  = 8'h09;
   localparam logic [7:0] CH_SP   = 8'h20;
   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_LF   = 8'h0A;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;
   localparam logic [7:0] CH_UA   = 8'h41;
   localparam logic [7:0] CH_UF   = 8'h46;
   localparam logic [7:0] CH_LA   = 8'h61;
   localparam logic [7:0] CH_LF_HEX = 8'h66;
   localparam logic [7:0] HEX_GAP = 8'd7;
   localparam logic [7:0] DIGIT_MAX = 8'd9;

   // Held blank codes
   typedef enum logic [1:0] {
      BLANK_TAB   = 2'd0,
      BLANK_SPACE = 2'd1,
      BLANK_CR    = 2'd2
   } blank_code_type;

   // Escape phase of the front
   typedef enum logic [1:0] {
      PH_OPEN = 2'd0,
      PH_EQ   = 2'd1,
      PH_HEX  = 2'd2
   } phase_type;

   // Sequencer stage of the back
   typedef enum logic [2:0] {
      ST_HEAD,
      ST_HEX,
      ST_BLANK,
      ST_BYTE,
      ST_TAIL
   } stage_type;

   // One classified input item, as the back carries it out:
   // [flush '=' + hex or blanks] [byte] [lone malformed '=']
   typedef struct packed {
      logic                 flush;
      logic                 flush_hex;
      logic [7:0]           hex_char;
      logic [CNT_W-1:0]     blank_count;
      logic                 first_main;
      logic                 put_blank;
      blank_code_type       put_code;
      logic [IDX_W-1:0]     put_idx;
      logic                 emit;
      logic [7:0]           emit_byte;
      logic                 tail;
   } cmd_type;

   // Queue status seen by front and back
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic is_hex_char(input logic [7:0] b);
      return ((b >= CH_ZERO) && (b <= CH_NINE)) ||
             ((b >= CH_UA) && (b <= CH_UF)) ||
             ((b >= CH_LA) && (b <= CH_LF_HEX));
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] b);
      logic [7:0] v;
      v = b - CH_ZERO;
      if (v > DIGIT_MAX) begin
         v = v - HEX_GAP;
      end
      return v[3:0];
   endfunction

   function automatic logic is_blank(input logic [7:0] b);
      return (b == CH_TAB) || (b == CH_SP) || (b == CH_CR);
   endfunction

   function automatic blank_code_type to_blank_code(input logic [7:0] b);
      blank_code_type c;
      case (b)
         CH_TAB:  c = BLANK_TAB;
         CH_CR:   c = BLANK_CR;
         default: c = BLANK_SPACE;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] blank_char(input blank_code_type c);
      logic [7:0] ch;
      case (c)
         BLANK_TAB: ch = CH_TAB;
         BLANK_CR:  ch = CH_CR;
         default:   ch = CH_SP;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

FILE: src/qpld_front.sv
// ----------------------------------------------------------------------------
// qpld_front
// Accepts encoded bytes, tracks the escape state and turns each byte into
// one command for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module qpld_front
   import qpld_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [7:0]       req_in_byte,
   input  wire logic             req_line_end,
   input  wire queue_status_type q_status,
   output logic                  push,
   output cmd_type               push_cmd
);

   phase_type        phase_ff, phase_in;
   logic [7:0]       hex_ff, hex_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             drop_ff, drop_in;
   logic             err_ff, err_in;
   logic             accept;
   logic             plain_after;
   cmd_type          cmd;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;
   assign push      = accept;
   assign push_cmd  = cmd;

   // Classify the byte against the escape state
   always_comb begin
      cmd         = '0;
      phase_in    = phase_ff;
      hex_in      = hex_ff;
      cnt_in      = cnt_ff;
      drop_in     = drop_ff;
      plain_after = 1'b0;
      cmd.first_main  = !err_ff;
      cmd.blank_count = cnt_ff;
      cmd.hex_char    = hex_ff;
      cmd.emit_byte   = req_in_byte;
      cmd.put_code    = to_blank_code(req_in_byte);
      cmd.put_idx     = cnt_ff[IDX_W-1:0];

      case (phase_ff)
         PH_EQ: begin
            if (is_blank(req_in_byte)) begin
               if ((cnt_ff < CNT_W'(BLANK_DEPTH)) && !req_line_end) begin
                  // hold the blank
                  cmd.put_blank = 1'b1;
                  cnt_in        = cnt_ff + CNT_W'(1);
               end else begin
                  // flush held blanks, pass this blank literally
                  cmd.flush = 1'b1;
                  cmd.emit  = 1'b1;
                  phase_in  = PH_OPEN;
                  cnt_in    = '0;
               end
            end else if (req_in_byte == CH_LF) begin
               // soft break: drop the rest of the line
               phase_in = PH_OPEN;
               cnt_in   = '0;
               drop_in  = 1'b1;
            end else if (is_hex_char(req_in_byte) && (cnt_ff == '0)) begin
               hex_in = req_in_byte;
               if (req_line_end) begin
                  cmd.flush     = 1'b1;
                  cmd.flush_hex = 1'b1;
                  cmd.hex_char  = req_in_byte;
                  phase_in      = PH_OPEN;
               end else begin
                  phase_in = PH_HEX;
               end
            end else begin
               cmd.flush   = 1'b1;
               plain_after = 1'b1;
            end
         end
         PH_HEX: begin
            if (is_hex_char(req_in_byte)) begin
               cmd.emit      = 1'b1;
               cmd.emit_byte = {hex_val(hex_ff), hex_val(req_in_byte)};
               phase_in      = PH_OPEN;
            end else begin
               cmd.flush       = 1'b1;
               cmd.flush_hex   = 1'b1;
               cmd.blank_count = '0;
               plain_after     = 1'b1;
            end
         end
         default: begin
            if (!drop_ff) begin
               if (req_in_byte == CH_EQ) begin
                  phase_in = PH_EQ;
                  cnt_in   = '0;
               end else begin
                  cmd.emit = 1'b1;
               end
            end
         end
      endcase

      // reprocess the byte that exposed a malformed escape
      if (plain_after) begin
         cnt_in = '0;
         if (req_in_byte == CH_EQ) begin
            phase_in = PH_EQ;
         end else begin
            cmd.emit = 1'b1;
            phase_in = PH_OPEN;
         end
      end

      // close the line: an escape still open here is a lone '=' with nothing held
      if (req_line_end) begin
         if (phase_in != PH_OPEN) begin
            if (cmd.flush) begin
               cmd.tail = 1'b1;
            end else begin
               cmd.flush       = 1'b1;
               cmd.flush_hex   = 1'b0;
               cmd.blank_count = '0;
            end
         end
         phase_in = PH_OPEN;
         cnt_in   = '0;
         drop_in  = 1'b0;
      end

      err_in = err_ff || cmd.flush || cmd.tail;
   end

   // Advance the escape state on each transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_OPEN;
         hex_ff   <= '0;
         cnt_ff   <= '0;
         drop_ff  <= 1'b0;
         err_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         hex_ff   <= hex_in;
         cnt_ff   <= cnt_in;
         drop_ff  <= drop_in;
         err_ff   <= err_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/qpld_queue.sv
// ----------------------------------------------------------------------------
// qpld_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module qpld_queue
   import qpld_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire cmd_type    push_cmd,
   input  wire logic       pop,
   output cmd_type         head,
   output queue_status_type status
);

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W:0]   fill_ff;
   logic              do_push;
   logic              do_pop;

   assign status.full  = (fill_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign status.empty = (fill_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = slot_ff[rd_ptr_ff];

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // Advance pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + (QPTR_W+1)'(1);
         end else if (do_pop && !do_push) begin
            fill_ff <= fill_ff - (QPTR_W+1)'(1);
         end
      end
   end

endmodule

`default_nettype wire

FILE: src/qpld_back.sv
// ----------------------------------------------------------------------------
// qpld_back
// Carries out queued commands: holds blanks in a small memory and steps
// through the result bytes of each command into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module qpld_back
   import qpld_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cmd_type          head,
   input  wire queue_status_type q_status,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_malformed,
   output logic                  rsp_first_error,
   output logic                  rsp_last
);

   blank_code_type   blank_mem [BLANK_DEPTH];
   blank_code_type   mem_q_ff;
   logic [IDX_W-1:0] rd_addr;

   stage_type        stage_ff, stage_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             valid_ff, valid_in;
   logic [7:0]       byte_ff, byte_in;
   logic             bad_ff, bad_in;
   logic             first_ff, first_in;
   logic             last_ff, last_in;

   logic             has_cmd;
   logic             out_free;
   logic             need;
   logic             advance;
   logic             to_done;
   stage_type        to_stage;
   logic             blank_last;
   logic             mid_done;
   stage_type        mid_stage;
   logic             eq_done;
   stage_type        eq_stage;
   logic             mem_we;

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_malformed   = bad_ff;
   assign rsp_first_error = first_ff;
   assign rsp_last        = last_ff;

   assign has_cmd    = !q_status.empty;
   assign out_free   = !valid_ff || !rsp_stall;
   assign blank_last = ((CNT_W'(idx_ff) + CNT_W'(1)) == head.blank_count);

   // Sequence the result bytes of the head command
   always_comb begin
      // what follows the hex digit or the blanks
      if (head.emit) begin
         mid_done  = 1'b0;
         mid_stage = ST_BYTE;
      end else begin
         mid_done  = !head.tail;
         mid_stage = ST_TAIL;
      end
      // what follows the malformed '='
      if (head.flush_hex) begin
         eq_done  = 1'b0;
         eq_stage = ST_HEX;
      end else if (head.blank_count != '0) begin
         eq_done  = 1'b0;
         eq_stage = ST_BLANK;
      end else begin
         eq_done  = mid_done;
         eq_stage = mid_stage;
      end

      need     = 1'b0;
      byte_in  = head.emit_byte;
      bad_in   = 1'b0;
      first_in = 1'b0;
      to_done  = 1'b1;
      to_stage = ST_HEAD;

      case (stage_ff)
         ST_HEAD: begin
            if (head.flush) begin
               need     = 1'b1;
               byte_in  = CH_EQ;
               bad_in   = 1'b1;
               first_in = head.first_main;
               to_done  = eq_done;
               to_stage = eq_stage;
            end else if (head.emit) begin
               need     = 1'b1;
               to_done  = !head.tail;
               to_stage = ST_TAIL;
            end else if (head.tail) begin
               need    = 1'b1;
               byte_in = CH_EQ;
               bad_in  = 1'b1;
            end
         end
         ST_HEX: begin
            need     = 1'b1;
            byte_in  = head.hex_char;
            to_done  = mid_done;
            to_stage = mid_stage;
         end
         ST_BLANK: begin
            need    = 1'b1;
            byte_in = blank_char(mem_q_ff);
            if (blank_last) begin
               to_done  = mid_done;
               to_stage = mid_stage;
            end else begin
               to_done  = 1'b0;
               to_stage = ST_BLANK;
            end
         end
         ST_BYTE: begin
            need     = 1'b1;
            to_done  = !head.tail;
            to_stage = ST_TAIL;
         end
         ST_TAIL: begin
            // the lone '=' always follows a reported flush, so never first
            need    = 1'b1;
            byte_in = CH_EQ;
            bad_in  = 1'b1;
         end
         default: begin
            to_done = 1'b0;
         end
      endcase

      last_in = to_done;
      advance = has_cmd && (!need || out_free);
      pop     = advance && to_done;
      mem_we  = pop && (stage_ff == ST_HEAD) && head.put_blank;

      stage_in = stage_ff;
      if (advance) begin
         stage_in = to_done ? ST_HEAD : to_stage;
      end

      // blank index and the read address one entry ahead
      idx_in  = idx_ff;
      rd_addr = '0;
      if (stage_ff == ST_HEAD) begin
         idx_in = '0;
      end else if (stage_ff == ST_BLANK) begin
         rd_addr = idx_ff;
         if (advance && !blank_last) begin
            idx_in  = idx_ff + IDX_W'(1);
            rd_addr = idx_ff + IDX_W'(1);
         end
      end

      // output register: load a beat, hold on stall, drop once taken
      if (out_free) begin
         valid_in = advance && need;
      end else begin
         valid_in = valid_ff;
      end
   end

   // Blank store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         blank_mem[head.put_idx] <= head.put_code;
      end
      mem_q_ff <= blank_mem[rd_addr];
   end

   // Output payload
   always_ff @(posedge clock) begin
      if (out_free && advance && need) begin
         byte_ff  <= byte_in;
         bad_ff   <= bad_in;
         first_ff <= first_in;
         last_ff  <= last_in;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= ST_HEAD;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         stage_ff <= stage_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/quoted_printable_line_decoder_top.sv
// Path: an accepted byte is written into the command queue, and its first result
//   is then loaded from the queue head into the output register.
// Throughput: one byte per cycle while each byte gives at most one result and
//   the queue is not full and the output not stalled; a byte with more results
//   holds the sequencer, while the four-entry command queue keeps input flowing.
// Reset: synchronous, active high; clears escape state, queue and output valid.
//   The blank store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// quoted_printable_line_decoder_top
// Quoted-printable line decoder: front classifier, command queue and
// result sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module quoted_printable_line_decoder_top
   import qpld_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_line_end,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_malformed,
   output logic            rsp_first_error,
   output logic            rsp_last
);

   queue_status_type q_status;
   logic             push;
   cmd_type          push_cmd;
   logic             pop;
   cmd_type          head;

   qpld_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .req_line_end (req_line_end),
      .q_status     (q_status),
      .push         (push),
      .push_cmd     (push_cmd)
   );

   qpld_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   qpld_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .q_status        (q_status),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_malformed   (rsp_malformed),
      .rsp_first_error (rsp_first_error),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

FILE: src/qpld_checker.sv
// ----------------------------------------------------------------------------
// qpld_checker
// Port-level checks on the decoder's result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module qpld_checker
   import qpld_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_malformed,
   input wire logic       rsp_first_error,
   input wire logic       rsp_last
);

   logic seen_ff;
   logic rsp_take;

   assign rsp_take = rsp_valid && !rsp_stall;

   // Track whether the one-shot warning was delivered
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else if (rsp_take && rsp_first_error) begin
         seen_ff <= 1'b1;
      end
   end

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last))
      else $error("stalled result changed");

   a_first_is_bad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_first_error |-> rsp_malformed)
      else $error("first error flag without malformed flag");

   a_bad_is_eq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_malformed |-> rsp_out_byte == CH_EQ)
      else $error("malformed flag on a byte other than equals");

   a_first_once: assert property (@(posedge clock) disable iff (reset)
      rsp_take && rsp_first_error |-> !seen_ff)
      else $error("first error flag delivered twice");

endmodule

bind quoted_printable_line_decoder_top qpld_checker u_checker (.*);

`default_nettype wire
